FILE: sv/ppi_keyboard_port_block_unit_assert.svh
// Assertion macros for the keyboard port block modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef PPI_KEYBOARD_PORT_BLOCK_UNIT_ASSERT_SVH
`define PPI_KEYBOARD_PORT_BLOCK_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define PPIKB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define PPIKB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ppikb_pkg.sv
// Types, codes and constants of the keyboard port block.
// No dependencies; imported by the interfaces, the controller, the datapath and the top.
`timescale 1ns / 1ps

package ppikb_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = COUNT_W + 1;

  localparam int PORT_W      = 16;
  localparam int DATA_W      = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_BASE_PORT    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIP_SWITCHES = 4'd1;

  localparam logic [PORT_W-1:0] BASE_PORT_RESET = 16'h0060;
  localparam logic [DATA_W-1:0] DIP_RESET       = 8'h30;

  // Port B bit that selects the high switch nibble
  localparam int SW_SEL_BIT = 3;

  localparam logic [1:0] OFF_SCAN    = 2'd0;
  localparam logic [1:0] OFF_PORT_B  = 2'd1;
  localparam logic [1:0] OFF_SWITCH  = 2'd2;
  localparam logic [1:0] OFF_CONTROL = 2'd3;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PUSH  = 2'd2,
    OP_POLL  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } ctrl_state_t;

  typedef struct packed {
    op_t               operation;
    logic [PORT_W-1:0] port;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] scan_code;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              port_hit;
    logic              irq_raised;
    logic              port_b_strobe;
    logic [DATA_W-1:0] port_b_value;
    logic              queue_overflow;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

FILE: sv/ppikb_in_if.sv
// Request channel of the keyboard port block.
// Depends on ppikb_pkg.
`timescale 1ns / 1ps

interface ppikb_in_if import ppikb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: sv/ppikb_out_if.sv
// Result channel of the keyboard port block.
// Depends on ppikb_pkg.
`timescale 1ns / 1ps

interface ppikb_out_if import ppikb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: sv/ppikb_cfg_if.sv
// Register write channel of the keyboard port block.
// Depends on ppikb_pkg.
`timescale 1ns / 1ps

interface ppikb_cfg_if import ppikb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  value;

  modport source (output valid, output index, output value, input ready);
  modport sink (input valid, input index, input value, output ready);
endinterface

FILE: sv/ppikb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ppikb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ppikb_ctrl.sv
// Sequencer of the keyboard port block: take an item, execute, hand over result.
// Depends on ppikb_pkg.
`timescale 1ns / 1ps

module ppikb_ctrl import ppikb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
      end
      ST_RESP: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/ppikb_dp.sv
// Datapath: item register, port registers, scan-code queue and latch, result.
// Depends on ppikb_pkg, ppikb_ram and the assertion header.
`timescale 1ns / 1ps
`include "ppi_keyboard_port_block_unit_assert.svh"

module ppikb_dp import ppikb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  input  in_item_t               in_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_value,
  output out_item_t              result
);

  in_item_t           item;
  logic [PORT_W-1:0]  base_port;
  logic [DATA_W-1:0]  dip_switches;
  logic [QUEUE_AW-1:0] queue_head, queue_head_next;
  logic [COUNT_W-1:0] queue_count, queue_count_next;
  logic [DATA_W-1:0]  scan_latch, scan_latch_next;
  logic               latch_full, latch_full_next;
  logic [DATA_W-1:0]  port_b_reg, port_b_reg_next;
  logic [DATA_W-1:0]  control_reg, control_reg_next;
  out_item_t          result_next;

  logic [DATA_W-1:0]   head_code;
  logic                q_we;
  logic [QUEUE_AW-1:0] q_tail;
  logic [SUM_W-1:0]    tail_sum;
  logic [PORT_W:0]     range_top;
  logic [PORT_W-1:0]   port_diff;
  logic [1:0]          offset;
  logic                hit;
  logic                queue_full;

  ppikb_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_tail),
    .wdata (item.scan_code),
    .raddr (queue_head),
    .rdata (head_code)
  );

  // range stops at the top of the address space, no wrap
  always_comb begin
    range_top  = {1'b0, base_port} + (PORT_W+1)'(3);
    port_diff  = item.port - base_port;
    offset     = port_diff[1:0];
    hit        = (item.operation == OP_READ || item.operation == OP_WRITE) &&
                 ({1'b0, item.port} >= {1'b0, base_port}) &&
                 ({1'b0, item.port} <= range_top);
    queue_full = (queue_count >= COUNT_W'(QUEUE_DEPTH));
    tail_sum   = SUM_W'(queue_head) + SUM_W'(queue_count);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    q_tail = tail_sum[QUEUE_AW-1:0];
    q_we   = cmd.execute && (item.operation == OP_PUSH) && !queue_full;
  end

  always_comb begin
    queue_head_next  = queue_head;
    queue_count_next = queue_count;
    scan_latch_next  = scan_latch;
    latch_full_next  = latch_full;
    port_b_reg_next  = port_b_reg;
    control_reg_next = control_reg;
    result_next      = '0;
    result_next.port_hit = hit;

    case (item.operation)
      OP_READ: begin
        if (hit) begin
          case (offset)
            OFF_SCAN: begin
              result_next.read_data = scan_latch;
              latch_full_next       = 1'b0;
            end
            OFF_PORT_B: result_next.read_data = port_b_reg;
            OFF_SWITCH: begin
              result_next.read_data = port_b_reg[SW_SEL_BIT] ?
                                      {4'b0, dip_switches[7:4]} :
                                      {4'b0, dip_switches[3:0]};
            end
            default: result_next.read_data = control_reg;
          endcase
        end
      end
      OP_WRITE: begin
        // writes to the input offsets are dropped
        if (hit && offset == OFF_PORT_B) begin
          port_b_reg_next           = item.write_data;
          result_next.port_b_strobe = 1'b1;
        end else if (hit && offset == OFF_CONTROL) begin
          control_reg_next = item.write_data;
        end
      end
      OP_PUSH: begin
        if (queue_full) begin
          result_next.queue_overflow = 1'b1;
        end else begin
          queue_count_next = queue_count + COUNT_W'(1);
        end
      end
      OP_POLL: begin
        if (!latch_full && queue_count != '0) begin
          scan_latch_next        = head_code;
          queue_head_next        = (queue_head == QUEUE_AW'(QUEUE_DEPTH - 1)) ?
                                   '0 : queue_head + QUEUE_AW'(1);
          queue_count_next       = queue_count - COUNT_W'(1);
          latch_full_next        = 1'b1;
          result_next.irq_raised = 1'b1;
        end
      end
      default: ;
    endcase
    result_next.port_b_value = port_b_reg_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
    end
    if (rst) begin
      result <= '0;
    end else if (cmd.execute) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_port    <= BASE_PORT_RESET;
      dip_switches <= DIP_RESET;
      queue_head   <= '0;
      queue_count  <= '0;
      scan_latch   <= '0;
      latch_full   <= 1'b0;
      port_b_reg   <= '0;
      control_reg  <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_BASE_PORT) begin
        base_port <= cfg_value;
      end
      if (cfg_we && cfg_index == REG_DIP_SWITCHES) begin
        dip_switches <= cfg_value[DATA_W-1:0];
      end
      if (cmd.execute) begin
        queue_head  <= queue_head_next;
        queue_count <= queue_count_next;
        scan_latch  <= scan_latch_next;
        latch_full  <= latch_full_next;
        port_b_reg  <= port_b_reg_next;
        control_reg <= control_reg_next;
      end
    end
  end

  `PPIKB_ASSERT_NOW(a_count_bound, clk, rst, 1'b1,
                    queue_count <= COUNT_W'(QUEUE_DEPTH), "queue count past depth")
  `PPIKB_ASSERT_NEXT(a_full_drop, clk, rst,
                     cmd.execute && item.operation == OP_PUSH && queue_full,
                     queue_count == COUNT_W'(QUEUE_DEPTH) && result.queue_overflow,
                     "push on full queue not dropped")
  `PPIKB_ASSERT_NEXT(a_poll_latch, clk, rst,
                     cmd.execute && item.operation == OP_POLL && !latch_full &&
                     queue_count != '0,
                     latch_full && result.irq_raised && scan_latch == $past(head_code),
                     "poll did not latch queue head")
  `PPIKB_ASSERT_NEXT(a_result_hold, clk, rst, !cmd.execute, $stable(result),
                     "result changed outside execute")

endmodule

FILE: sv/ppi_keyboard_port_block_unit.sv
// Keyboard port block: one item at a time, controller plus datapath.
// The request item is captured in ST_IDLE, executed in ST_EXEC, where the
// result is registered, and offered in ST_RESP until it is taken.
// Steps per item: take, execute, hand over; the sequencer holds one item
// from acceptance until its result is taken, so no new item is taken before.
// Reset (rst, synchronous): base 0x60, switches 0x30, queue empty, latch free.
`timescale 1ns / 1ps

module ppi_keyboard_port_block_unit import ppikb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ppikb_in_if.sink    req,
  ppikb_out_if.source rsp,
  ppikb_cfg_if.sink   cfg
);

  ctrl_cmd_t cmd;
  logic      in_ready;
  logic      out_valid;

  // register writes are always taken
  assign cfg.ready = 1'b1;
  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  ppikb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  ppikb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (req.item),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_value (cfg.value),
    .result    (rsp.item)
  );

endmodule
